>>> rtl/core/ecma_pkg.sv
// ----------------------------------------------------------------------------
// ecma_pkg
// Shared constants, reciprocal table and control types for the edge-clipped
// moving average.
// ----------------------------------------------------------------------------
package ecma_pkg;

  localparam int unsigned MAX_HALF    = 16;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned HW_BITS     = 5;
  localparam int unsigned LINE_DEPTH  = 2 * MAX_HALF + 1;
  localparam int unsigned PTR_BITS    = $clog2(LINE_DEPTH);
  localparam int unsigned CNT_BITS    = $clog2(LINE_DEPTH + 1);
  localparam int unsigned HALF_BITS   = $clog2(MAX_HALF + 1);
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + CNT_BITS;
  localparam int unsigned MAG_BITS    = SUM_BITS - 1;
  localparam int unsigned QUO_BITS    = SAMPLE_BITS + 1;
  localparam int unsigned RCP_SHIFT   = MAG_BITS + CNT_BITS;
  localparam int unsigned RCP_BITS    = RCP_SHIFT + 1;

  localparam logic [HW_BITS-1:0] HW_RESET = HW_BITS'(1);

  localparam longint unsigned RCP_NUM = 64'd1 << RCP_SHIFT;

  // ceil(2^RCP_SHIFT / n), exact floor division for every |sum| and count
  localparam logic [RCP_BITS-1:0] RCP_TBL [LINE_DEPTH+1] = '{
    RCP_BITS'(0),
    RCP_BITS'((RCP_NUM +  0) /  1), RCP_BITS'((RCP_NUM +  1) /  2),
    RCP_BITS'((RCP_NUM +  2) /  3), RCP_BITS'((RCP_NUM +  3) /  4),
    RCP_BITS'((RCP_NUM +  4) /  5), RCP_BITS'((RCP_NUM +  5) /  6),
    RCP_BITS'((RCP_NUM +  6) /  7), RCP_BITS'((RCP_NUM +  7) /  8),
    RCP_BITS'((RCP_NUM +  8) /  9), RCP_BITS'((RCP_NUM +  9) / 10),
    RCP_BITS'((RCP_NUM + 10) / 11), RCP_BITS'((RCP_NUM + 11) / 12),
    RCP_BITS'((RCP_NUM + 12) / 13), RCP_BITS'((RCP_NUM + 13) / 14),
    RCP_BITS'((RCP_NUM + 14) / 15), RCP_BITS'((RCP_NUM + 15) / 16),
    RCP_BITS'((RCP_NUM + 16) / 17), RCP_BITS'((RCP_NUM + 17) / 18),
    RCP_BITS'((RCP_NUM + 18) / 19), RCP_BITS'((RCP_NUM + 19) / 20),
    RCP_BITS'((RCP_NUM + 20) / 21), RCP_BITS'((RCP_NUM + 21) / 22),
    RCP_BITS'((RCP_NUM + 22) / 23), RCP_BITS'((RCP_NUM + 23) / 24),
    RCP_BITS'((RCP_NUM + 24) / 25), RCP_BITS'((RCP_NUM + 25) / 26),
    RCP_BITS'((RCP_NUM + 26) / 27), RCP_BITS'((RCP_NUM + 27) / 28),
    RCP_BITS'((RCP_NUM + 28) / 29), RCP_BITS'((RCP_NUM + 29) / 30),
    RCP_BITS'((RCP_NUM + 30) / 31), RCP_BITS'((RCP_NUM + 31) / 32),
    RCP_BITS'((RCP_NUM + 32) / 33)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_TRIM,
    ST_SUB,
    ST_DEMIT
  } ecma_state_e;

  typedef struct packed {
    logic accept;
    logic emit;
    logic emit_drain;
    logic drain_init;
    logic drain_rd;
    logic sub;
    logic dist_dec;
    logic clear_run;
  } ecma_cmd_t;

  typedef struct packed {
    logic seen_ge_h1;
    logic last;
    logic h_zero;
    logic top_gt_target;
    logic dist_in_run;
    logic dist_zero;
    logic div_rdy;
  } ecma_sts_t;

endpackage

>>> rtl/core/edge_clipped_moving_average_top.sv
// ----------------------------------------------------------------------------
// edge_clipped_moving_average_top
// Centered moving average over a run of samples, window clipped at both ends.
// ----------------------------------------------------------------------------
// Path: a result passes the check state, then the divider's lookup, multiply and
//   output registers. Items: one is taken at a time, paced by the single-port
//   delay-line read that feeds the running sum and held while the divider is full.
//   The last item of a run adds trimmed samples, drained results and offsets past a short run.
// Reset: half_width = 1, run empty; the delay line is not cleared.
module edge_clipped_moving_average_top import ecma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [15:0] sample
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // [15:0] smoothed
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [HW_BITS-1:0]     cfg_data_i
);

  ecma_cmd_t cmd;
  ecma_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ecma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ecma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.div_rdy)
    else $error("result issued while divider full");

  a_sub_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sub |-> $past(cmd.drain_rd))
    else $error("window trim without a preceding line read");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !s_axis_tready)
    else $error("item taken before oldest sample was refetched");

endmodule

>>> rtl/core/ecma_div.sv
// ----------------------------------------------------------------------------
// ecma_div
// Elastic three-register divider: magnitude and reciprocal lookup, multiply,
// sign restore into the output register.
// ----------------------------------------------------------------------------
module ecma_div import ecma_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_BITS-1:0] sum_i,
  input  logic [CNT_BITS-1:0]        cnt_i,
  input  logic                       last_i,
  output logic                       rdy_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [SAMPLE_BITS-1:0]     out_data_o,
  output logic                       out_last_o
);

  logic                         v1_q, v2_q, vo_q;
  logic [MAG_BITS-1:0]          mag1_q;
  logic [RCP_BITS-1:0]          rcp1_q;
  logic                         neg1_q, last1_q;
  logic [QUO_BITS-1:0]          quo2_q;
  logic                         neg2_q, last2_q;
  logic [SAMPLE_BITS-1:0]       data_q;
  logic                         lasto_q;
  logic                         en1, en2, eno;
  logic [SUM_BITS-1:0]          mag_full;
  logic [MAG_BITS+RCP_BITS-1:0] prod;
  logic [QUO_BITS-1:0]          quo_neg;

  assign eno = !vo_q || out_ready_i;
  assign en2 = !v2_q || eno;
  assign en1 = !v1_q || en2;
  assign rdy_o = en1;

  assign mag_full = sum_i[SUM_BITS-1] ? (~sum_i + SUM_BITS'(1)) : sum_i;
  assign prod = {{RCP_BITS{1'b0}}, mag1_q} * {{MAG_BITS{1'b0}}, rcp1_q};
  assign quo_neg = ~quo2_q + QUO_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= start_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (eno) begin
        vo_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && start_i) begin
      mag1_q  <= mag_full[MAG_BITS-1:0];
      rcp1_q  <= RCP_TBL[cnt_i];
      neg1_q  <= sum_i[SUM_BITS-1];
      last1_q <= last_i;
    end
    if (en2 && v1_q) begin
      quo2_q  <= prod[RCP_SHIFT +: QUO_BITS];
      neg2_q  <= neg1_q;
      last2_q <= last1_q;
    end
    if (eno && v2_q) begin
      data_q  <= neg2_q ? quo_neg[SAMPLE_BITS-1:0] : quo2_q[SAMPLE_BITS-1:0];
      lasto_q <= last2_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = data_q;
  assign out_last_o  = lasto_q;

endmodule

>>> rtl/core/ecma_dp.sv
// ----------------------------------------------------------------------------
// ecma_dp
// Datapath: half-width register, circular delay line, running window sum,
// drain counters and the divider.
// ----------------------------------------------------------------------------
module ecma_dp import ecma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ecma_cmd_t              cmd_i,
  output ecma_sts_t              sts_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  input  logic                   cfg_valid_i,
  input  logic [HW_BITS-1:0]     cfg_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [SAMPLE_BITS-1:0] out_data_o,
  output logic                   out_last_o
);

  logic [HW_BITS-1:0]         hw_q;
  logic [PTR_BITS-1:0]        wp_q, wp_d;
  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic [CNT_BITS-1:0]        seen_q, seen_d;
  logic                       last_q;
  logic [PTR_BITS-1:0]        top_q, top_d;
  logic [HALF_BITS-1:0]       dist_q, dist_d;
  logic [SAMPLE_BITS-1:0]     mem [LINE_DEPTH];
  logic [SAMPLE_BITS-1:0]     rd_q;

  logic [HALF_BITS-1:0]       h;
  logic [CNT_BITS-1:0]        w;
  logic [PTR_BITS-1:0]        rd_k;
  logic [PTR_BITS-1:0]        rd_addr;
  logic [SUM_BITS-1:0]        s_ext, rd_ext, old_ext;
  logic [CNT_BITS-1:0]        dh, sm1, target;
  logic [CNT_BITS-1:0]        div_cnt;
  logic                       div_last;

  function automatic logic [PTR_BITS-1:0] line_addr(input logic [PTR_BITS-1:0] wp,
                                                    input logic [PTR_BITS-1:0] k);
    logic [PTR_BITS:0] diff;
    diff = {1'b0, wp} - {1'b0, k} - (PTR_BITS+1)'(1);
    if (diff[PTR_BITS]) begin
      diff = diff + (PTR_BITS+1)'(LINE_DEPTH);
    end
    return diff[PTR_BITS-1:0];
  endfunction

  assign h = (hw_q > HW_BITS'(MAX_HALF)) ? HALF_BITS'(MAX_HALF) : HALF_BITS'(hw_q);
  assign w = {h, 1'b1};

  assign rd_k    = cmd_i.drain_rd ? top_q : PTR_BITS'({h, 1'b0});
  assign rd_addr = line_addr(wp_q, rd_k);

  assign s_ext   = {{(SUM_BITS-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign rd_ext  = {{(SUM_BITS-SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q};
  assign old_ext = (seen_q >= w) ? rd_ext : '0;

  assign dh     = {1'b0, dist_q} + {1'b0, h};
  assign sm1    = seen_q - CNT_BITS'(1);
  assign target = (dh < sm1) ? dh : sm1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[wp_q] <= sample_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    wp_d   = wp_q;
    sum_d  = sum_q;
    seen_d = seen_q;
    top_d  = top_q;
    dist_d = dist_q;
    if (cmd_i.accept) begin
      wp_d  = (wp_q == PTR_BITS'(LINE_DEPTH - 1)) ? '0 : wp_q + PTR_BITS'(1);
      sum_d = sum_q + s_ext - old_ext;
      if (seen_q < w) begin
        seen_d = seen_q + CNT_BITS'(1);
      end
    end
    if (cmd_i.sub) begin
      sum_d = sum_q - rd_ext;
      top_d = top_q - PTR_BITS'(1);
    end
    if (cmd_i.drain_init) begin
      dist_d = h - HALF_BITS'(1);
      top_d  = PTR_BITS'(sm1);
    end
    if (cmd_i.dist_dec) begin
      dist_d = dist_q - HALF_BITS'(1);
    end
    if (cmd_i.clear_run || cfg_valid_i) begin
      sum_d  = '0;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q   <= HW_RESET;
      wp_q   <= '0;
      sum_q  <= '0;
      seen_q <= '0;
      top_q  <= '0;
      dist_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        hw_q <= cfg_data_i;
      end
      wp_q   <= wp_d;
      sum_q  <= sum_d;
      seen_q <= seen_d;
      top_q  <= top_d;
      dist_q <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      last_q <= last_i;
    end
  end

  assign div_cnt  = cmd_i.emit_drain ? CNT_BITS'(top_q) + CNT_BITS'(1) : seen_q;
  assign div_last = cmd_i.emit_drain ? (dist_q == '0) : (last_q && (h == '0));

  ecma_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.emit),
    .sum_i       (sum_q),
    .cnt_i       (div_cnt),
    .last_i      (div_last),
    .rdy_o       (sts_o.div_rdy),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_last_o  (out_last_o)
  );

  assign sts_o.seen_ge_h1    = seen_q > CNT_BITS'(h);
  assign sts_o.last          = last_q;
  assign sts_o.h_zero        = (h == '0);
  assign sts_o.top_gt_target = CNT_BITS'(top_q) > target;
  assign sts_o.dist_in_run   = CNT_BITS'(dist_q) < seen_q;
  assign sts_o.dist_zero     = (dist_q == '0);

endmodule

>>> rtl/core/ecma_ctrl.sv
// ----------------------------------------------------------------------------
// ecma_ctrl
// Controller: takes one item, issues its result, and sequences the end-of-run
// drain by trimming the window sum from the oldest end.
// ----------------------------------------------------------------------------
module ecma_ctrl import ecma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ecma_sts_t sts_i,
  output ecma_cmd_t cmd_o
);

  ecma_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!sts_i.seen_ge_h1 || sts_i.div_rdy) begin
          if (sts_i.last && !sts_i.h_zero) begin
            state_d = ST_TRIM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TRIM: begin
        if (sts_i.top_gt_target) begin
          state_d = ST_SUB;
        end else if (sts_i.dist_in_run) begin
          state_d = ST_DEMIT;
        end
      end
      ST_SUB: begin
        state_d = ST_TRIM;
      end
      ST_DEMIT: begin
        if (sts_i.div_rdy) begin
          state_d = sts_i.dist_zero ? ST_IDLE : ST_TRIM;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_CHK: begin
        if (!sts_i.seen_ge_h1 || sts_i.div_rdy) begin
          cmd_o.emit = sts_i.seen_ge_h1;
          if (sts_i.last) begin
            if (sts_i.h_zero) begin
              cmd_o.clear_run = 1'b1;
            end else begin
              cmd_o.drain_init = 1'b1;
            end
          end
        end
      end
      ST_TRIM: begin
        cmd_o.drain_rd = 1'b1;
        if (!sts_i.top_gt_target && !sts_i.dist_in_run) begin
          cmd_o.dist_dec = 1'b1;
        end
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
      end
      ST_DEMIT: begin
        if (sts_i.div_rdy) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_drain = 1'b1;
          if (sts_i.dist_zero) begin
            cmd_o.clear_run = 1'b1;
          end else begin
            cmd_o.dist_dec = 1'b1;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
